@@ rtl/msn_pkg.sv @@
// ============================================================================
// msn_pkg
// Shared types and constants of the mask smooth and normalize unit.
// ============================================================================
package msn_pkg;

    localparam int MSN_MAX_SIDE = 128;

    // Input item commands.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Result kinds.
    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Register index, taken from address bit 2.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] pixel_index;
        logic [7:0]  pixel_value;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] result_value;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_TAP,
        ST_LAST,
        ST_PEAK,
        ST_NRD,
        ST_NMUL,
        ST_NDIV,
        ST_NWR,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_EDGE,
        PH_INNER,
        PH_SIDE
    } t_phase;

endpackage

@@ rtl/msn_ram.sv @@
// ============================================================================
// msn_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module msn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mask_smooth_and_normalize_unit.sv @@
// ============================================================================
// mask_smooth_and_normalize_unit
// Loads an 8-bit mask into a RAM, smooths it in place four times, scales it
// to its peak and serves the pixels back by index.
// A load is written at its accept edge; a read result is registered in the
// RAM read data and then in the output register; a run scales only when its
// peak is nonzero. Loads are taken one per cycle while no result waits at a
// stalled output; a read or run ends before the next item is taken. A run is
// bounded by the single RAM read port, one neighbor tap per cycle. Reset
// (synchronous, active low) sets both sizes to 128 and clears the peak and the FSM state; RAM contents are kept.
// ============================================================================
module mask_smooth_and_normalize_unit
    import msn_pkg::*;
#(
    parameter int MAX_SIDE = MSN_MAX_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Store geometry. SW holds a side length, AW a RAM address, NW a pixel
    // count up to and including the full store, PW a row times width product.
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int PW    = 2 * SW;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic            r_bot, n_bot;
    logic [SW-1:0]   r_row, n_row, r_col, n_col;
    logic [1:0]      r_ty, n_ty, r_tx, n_tx;
    logic [1:0]      r_pass, n_pass;
    logic [11:0]     r_acc, n_acc;
    logic            r_tap_ok, n_tap_ok, r_tap_c8, n_tap_c8;
    logic [SW-1:0]   r_w, n_w, r_b, n_b, r_e, n_e;
    logic [NW-1:0]   r_n, n_n, r_lin, n_lin;
    logic            r_pk_vld, n_pk_vld;
    logic [7:0]      r_peak, n_peak;
    logic [15:0]     r_dvd, n_dvd;
    logic [7:0]      r_rem, n_rem;
    logic [3:0]      r_dcnt, n_dcnt;
    logic            r_rd_oor, n_rd_oor;
    logic            r_o_valid, n_o_valid;
    t_out_item       r_o_data, n_o_data;
    logic [7:0]      r_wreg, r_hreg;

    // RAM ports
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]      ram_wdata, ram_rdata;

    msn_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Configuration port. The user writes only while the unit is idle; the
    // block does not enforce it. A run latches the clamped sizes once at its start.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {24'd0, r_hreg} : {24'd0, r_wreg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wreg <= 8'd128;
            r_hreg <= 8'd128;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HEIGHT) begin
                r_hreg <= pwdata[7:0];
            end else begin
                r_wreg <= pwdata[7:0];
            end
        end
    end

    // Each effective side is the register clamped to 3..MAX_SIDE.
    logic [31:0]   w_cl, h_cl;
    logic [SW-1:0] w_eff, h_eff;

    always_comb begin
        w_cl = 32'(r_wreg);
        h_cl = 32'(r_hreg);
        if (w_cl < 32'd3) begin
            w_cl = 32'd3;
        end else if (w_cl > 32'(MAX_SIDE)) begin
            w_cl = 32'(MAX_SIDE);
        end
        if (h_cl < 32'd3) begin
            h_cl = 32'd3;
        end else if (h_cl > 32'(MAX_SIDE)) begin
            h_cl = 32'(MAX_SIDE);
        end
        w_eff = SW'(w_cl);
        h_eff = SW'(h_cl);
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic in_acc, idx_ok;
    assign o_in_ready = (r_state == ST_IDLE) && (!r_o_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign idx_ok     = 32'(i_in_data.pixel_index) < 32'(DEPTH);

    // Smoothing: a pixel is computed from its 3x3 window, one tap per cycle.
    // Taps outside the mask are skipped. A corner weights its 2x2 block by
    // one each and shifts by two; every other pixel weights its centre by
    // eight and shifts by four, which covers edges and interior alike.
    logic          corner, first_tap, last_tap, tap_ok, tap_c8, pix_last;
    logic [SW-1:0] tap_r, tap_c;
    logic [PW-1:0] tap_prod;
    logic [AW-1:0] tap_addr;
    logic [11:0]   contrib, pix_sum;

    assign corner    = ((r_row == '0) || (r_row == r_b)) && ((r_col == '0) || (r_col == r_e));
    assign first_tap = (r_ty == 2'd0) && (r_tx == 2'd0);
    assign last_tap  = (r_ty == 2'd2) && (r_tx == 2'd2);
    assign tap_ok    = !((r_row == '0) && (r_ty == 2'd0)) && !((r_row == r_b) && (r_ty == 2'd2))
                    && !((r_col == '0) && (r_tx == 2'd0)) && !((r_col == r_e) && (r_tx == 2'd2));
    assign tap_c8    = (r_ty == 2'd1) && (r_tx == 2'd1) && !corner;

    // In the write cycle the address is the centre pixel itself.
    assign tap_r    = (r_state == ST_LAST) ? r_row : r_row + SW'(r_ty) - SW'(1);
    assign tap_c    = (r_state == ST_LAST) ? r_col : r_col + SW'(r_tx) - SW'(1);
    assign tap_prod = PW'(tap_r) * PW'(r_w) + PW'(tap_c);
    assign tap_addr = tap_prod[AW-1:0];

    assign contrib  = !r_tap_ok ? 12'd0 :
                      (r_tap_c8 ? {1'b0, ram_rdata, 3'b000} : {4'd0, ram_rdata});
    assign pix_sum  = r_acc + contrib;

    // The last pixel of a pass is the right side pixel of the last inner row.
    assign pix_last = (r_phase == PH_SIDE) && (r_col != '0) && (r_row == r_b - SW'(1));

    // Peak sweep and restoring divider.
    logic [7:0] peak_nx;
    logic [8:0] trial;
    assign peak_nx = (r_pk_vld && (ram_rdata > r_peak)) ? ram_rdata : r_peak;
    assign trial   = {r_rem, r_dvd[15]};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.mode)
                        MODE_RUN:  n_state = ST_TAP;
                        MODE_READ: n_state = ST_READ;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_TAP: begin
                if (last_tap) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = (pix_last && (r_pass == 2'd3)) ? ST_PEAK : ST_TAP;
            end
            ST_PEAK: begin
                if (r_lin == r_n) begin
                    n_state = (peak_nx != 8'd0) ? ST_NRD : ST_FIN;
                end
            end
            ST_NRD:  n_state = ST_NMUL;
            ST_NMUL: n_state = ST_NDIV;
            ST_NDIV: begin
                if (r_dcnt == 4'd15) begin
                    n_state = ST_NWR;
                end
            end
            ST_NWR: begin
                n_state = (r_lin == r_n - NW'(1)) ? ST_FIN : ST_NRD;
            end
            ST_FIN: begin
                if (!r_o_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_bot     = r_bot;
        n_row     = r_row;
        n_col     = r_col;
        n_ty      = r_ty;
        n_tx      = r_tx;
        n_pass    = r_pass;
        n_acc     = r_acc;
        n_tap_ok  = r_tap_ok;
        n_tap_c8  = r_tap_c8;
        n_w       = r_w;
        n_b       = r_b;
        n_e       = r_e;
        n_n       = r_n;
        n_lin     = r_lin;
        n_pk_vld  = r_pk_vld;
        n_peak    = r_peak;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_rd_oor  = r_rd_oor;
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_data  = r_o_data;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = '0;
        ram_raddr = '0;
        ram_wdata = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.mode)
                        MODE_LOAD: begin
                            ram_we    = idx_ok;
                            ram_waddr = AW'(i_in_data.pixel_index);
                            ram_wdata = i_in_data.pixel_value;
                        end
                        MODE_RUN: begin
                            n_w      = w_eff;
                            n_b      = h_eff - SW'(1);
                            n_e      = w_eff - SW'(1);
                            n_n      = NW'(NW'(w_eff) * NW'(h_eff));
                            n_phase  = PH_EDGE;
                            n_bot    = 1'b0;
                            n_row    = '0;
                            n_col    = '0;
                            n_ty     = 2'd0;
                            n_tx     = 2'd0;
                            n_pass   = 2'd0;
                            n_tap_ok = 1'b0;
                        end
                        MODE_READ: begin
                            ram_re    = idx_ok;
                            ram_raddr = AW'(i_in_data.pixel_index);
                            n_rd_oor  = !idx_ok;
                        end
                        default: ;
                    endcase
                end
            end

            ST_READ: begin
                n_o_valid = 1'b1;
                n_o_data  = '{result_kind: KIND_READ,
                              result_value: r_rd_oor ? 8'd0 : ram_rdata};
            end

            ST_TAP: begin
                ram_re    = 1'b1;
                ram_raddr = tap_addr;
                n_tap_ok  = tap_ok;
                n_tap_c8  = tap_c8;
                n_acc     = (first_tap ? 12'd0 : r_acc) + contrib;
                if (r_tx == 2'd2) begin
                    n_tx = 2'd0;
                    n_ty = r_ty + 2'd1;
                end else begin
                    n_tx = r_tx + 2'd1;
                end
            end

            ST_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = tap_addr;
                ram_wdata = corner ? pix_sum[9:2] : pix_sum[11:4];
                n_tap_ok  = 1'b0;
                n_ty      = 2'd0;
                n_tx      = 2'd0;
                // Walk the fixed update order: top and bottom rows column by
                // column, then the interior in raster order, then the left
                // and right columns row by row.
                case (r_phase)
                    PH_EDGE: begin
                        if (!r_bot) begin
                            n_bot = 1'b1;
                            n_row = r_b;
                        end else begin
                            n_bot = 1'b0;
                            n_row = '0;
                            if (r_col == r_e) begin
                                n_phase = PH_INNER;
                                n_row   = SW'(1);
                                n_col   = SW'(1);
                            end else begin
                                n_col = r_col + SW'(1);
                            end
                        end
                    end
                    PH_INNER: begin
                        if (r_col == r_e - SW'(1)) begin
                            n_col = SW'(1);
                            if (r_row == r_b - SW'(1)) begin
                                n_phase = PH_SIDE;
                                n_row   = SW'(1);
                                n_col   = '0;
                            end else begin
                                n_row = r_row + SW'(1);
                            end
                        end else begin
                            n_col = r_col + SW'(1);
                        end
                    end
                    PH_SIDE: begin
                        if (r_col == '0) begin
                            n_col = r_e;
                        end else begin
                            n_col = '0;
                            if (pix_last) begin
                                n_phase  = PH_EDGE;
                                n_row    = '0;
                                n_pass   = r_pass + 2'd1;
                                n_lin    = '0;
                                n_peak   = 8'd0;
                                n_pk_vld = 1'b0;
                            end else begin
                                n_row = r_row + SW'(1);
                            end
                        end
                    end
                    default: n_phase = PH_EDGE;
                endcase
            end

            ST_PEAK: begin
                n_peak = peak_nx;
                if (r_lin != r_n) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_lin[AW-1:0];
                    n_lin     = r_lin + NW'(1);
                    n_pk_vld  = 1'b1;
                end else begin
                    n_pk_vld = 1'b0;
                    n_lin    = '0;
                end
            end

            ST_NRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_lin[AW-1:0];
            end

            ST_NMUL: begin
                // value * 255 as (value << 8) - value
                n_dvd  = {ram_rdata, 8'd0} - {8'd0, ram_rdata};
                n_rem  = 8'd0;
                n_dcnt = 4'd0;
            end

            ST_NDIV: begin
                n_dcnt = r_dcnt + 4'd1;
                if (trial >= {1'b0, r_peak}) begin
                    n_rem = 8'(trial - {1'b0, r_peak});
                    n_dvd = {r_dvd[14:0], 1'b1};
                end else begin
                    n_rem = trial[7:0];
                    n_dvd = {r_dvd[14:0], 1'b0};
                end
            end

            ST_NWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_lin[AW-1:0];
                ram_wdata = r_dvd[7:0];
                n_lin     = r_lin + NW'(1);
            end

            ST_FIN: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = '{result_kind: KIND_RUN, result_value: r_peak};
                end
            end

            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_EDGE;
            r_bot     <= 1'b0;
            r_ty      <= 2'd0;
            r_tx      <= 2'd0;
            r_pass    <= 2'd0;
            r_tap_ok  <= 1'b0;
            r_pk_vld  <= 1'b0;
            r_peak    <= 8'd0;
            r_dcnt    <= 4'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_bot     <= n_bot;
            r_ty      <= n_ty;
            r_tx      <= n_tx;
            r_pass    <= n_pass;
            r_tap_ok  <= n_tap_ok;
            r_pk_vld  <= n_pk_vld;
            r_peak    <= n_peak;
            r_dcnt    <= n_dcnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_acc    <= n_acc;
        r_tap_c8 <= n_tap_c8;
        r_w      <= n_w;
        r_b      <= n_b;
        r_e      <= n_e;
        r_n      <= n_n;
        r_lin    <= n_lin;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_rd_oor <= n_rd_oor;
        r_o_data <= n_o_data;
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No write may land while a pixel's taps are still being read.
    a_no_write_in_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAP) |-> !ram_we)
        else $error("store written during tap reads");

    // An accepted run leaves idle on the next cycle.
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.mode == MODE_RUN)) |=> (r_state == ST_TAP))
        else $error("run did not start");

    // A read result follows its accept through the RAM read register and the output register.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.mode == MODE_READ)) |=> ##1 o_out_valid)
        else $error("read result missing");

    // The output register is free whenever a read result is about to be loaded.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_o_valid)
        else $error("read result would overwrite a pending result");

    // The sweep pointer never passes the pixel count.
    a_lin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PEAK) || (r_state == ST_NRD)) |-> (r_lin <= r_n))
        else $error("sweep pointer out of range");

endmodule

@@ tb/mask_smooth_and_normalize_unit_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// mask_smooth_and_normalize_unit_tb
// Self-checking bench for the mask smooth and normalize unit. A directed
// table covers the field extremes, the ignored command, the far end of the
// store, a zero peak and size clamping. It is followed by random phases at
// several mask sizes. Every result item is checked against its typed value or a
// local predictor of the smoothing, peak and scaling behavior.
// ============================================================================
module mask_smooth_and_normalize_unit_tb;
    import msn_pkg::*;

    localparam int DEPTH = MSN_MAX_SIDE * MSN_MAX_SIDE;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mask_smooth_and_normalize_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Mirror of the mask RAM, the written-entry map and the size registers.
    logic [7:0] mask_img [DEPTH];
    bit         loaded [DEPTH];
    int         loaded_list[$];
    logic [7:0] reg_width;
    logic [7:0] reg_height;
    logic [7:0] last_peak;

    t_out_item  pending_results[$];
    int         fail_count;
    int         send_idle_pct;
    int         recv_stall_pct;

    // One row of the directed table. Where check is set, the expected result
    // is typed in; otherwise the predictor supplies it.
    typedef struct {
        t_in_item  item;
        bit        check;
        t_out_item result;
    } t_row;
    t_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("mask_smooth_and_normalize_unit_tb NOT OK");
        $finish;
    end

    function automatic int side_of(logic [7:0] v);
        if (v < 3) return 3;
        if (v > MSN_MAX_SIDE) return MSN_MAX_SIDE;
        return v;
    endfunction

    // Four in-place passes, then peak search and scaling, over the mirror.
    // Corner sums are widened to int so that they cannot wrap at 8 bits.
    function automatic logic [7:0] smooth_and_scale();
        int w, h, b, e, r, c, k, n, pk, i;
        w = side_of(reg_width);
        h = side_of(reg_height);
        b = h - 1;
        e = w - 1;
        n = w * h;
        for (k = 0; k < 4; k++) begin
            mask_img[0] = (int'(mask_img[0]) + mask_img[1] + mask_img[w]
                           + mask_img[w+1]) >> 2;
            mask_img[b*w] = (int'(mask_img[b*w]) + mask_img[b*w+1] + mask_img[(b-1)*w]
                             + mask_img[(b-1)*w+1]) >> 2;
            for (c = 1; c < e; c++) begin
                mask_img[c] = (mask_img[c-1] + 8 * mask_img[c] + mask_img[c+1]
                               + mask_img[w+c-1] + mask_img[w+c] + mask_img[w+c+1]) >> 4;
                mask_img[b*w+c] = (mask_img[b*w+c-1] + 8 * mask_img[b*w+c]
                                   + mask_img[b*w+c+1] + mask_img[(b-1)*w+c-1]
                                   + mask_img[(b-1)*w+c] + mask_img[(b-1)*w+c+1]) >> 4;
            end
            mask_img[e] = (int'(mask_img[e-1]) + mask_img[e] + mask_img[w+e-1]
                           + mask_img[w+e]) >> 2;
            mask_img[b*w+e] = (int'(mask_img[b*w+e-1]) + mask_img[b*w+e]
                               + mask_img[(b-1)*w+e-1] + mask_img[(b-1)*w+e]) >> 2;
            for (r = 1; r < b; r++)
                for (c = 1; c < e; c++)
                    mask_img[r*w+c] = (mask_img[(r-1)*w+c-1] + mask_img[(r-1)*w+c]
                                       + mask_img[(r-1)*w+c+1] + mask_img[r*w+c-1]
                                       + 8 * mask_img[r*w+c] + mask_img[r*w+c+1]
                                       + mask_img[(r+1)*w+c-1] + mask_img[(r+1)*w+c]
                                       + mask_img[(r+1)*w+c+1]) >> 4;
            for (r = 1; r < b; r++) begin
                mask_img[r*w] = (mask_img[(r-1)*w] + mask_img[(r-1)*w+1] + 8 * mask_img[r*w]
                                 + mask_img[r*w+1] + mask_img[(r+1)*w]
                                 + mask_img[(r+1)*w+1]) >> 4;
                mask_img[r*w+e] = (mask_img[(r-1)*w+e-1] + mask_img[(r-1)*w+e]
                                   + mask_img[r*w+e-1] + 8 * mask_img[r*w+e]
                                   + mask_img[(r+1)*w+e-1] + mask_img[(r+1)*w+e]) >> 4;
            end
        end
        pk = 0;
        for (i = 0; i < n; i++)
            if (mask_img[i] > pk) pk = mask_img[i];
        if (pk > 0)
            for (i = 0; i < n; i++)
                mask_img[i] = (mask_img[i] * 255) / pk;
        return pk[7:0];
    endfunction

    // Updates the mirror for an accepted item and returns whether a result
    // item is due, with its expected contents.
    function automatic bit predict_item(t_in_item it, output t_out_item res);
        res = '0;
        case (it.mode)
            MODE_LOAD: begin
                mask_img[it.pixel_index] = it.pixel_value;
                if (!loaded[it.pixel_index]) begin
                    loaded[it.pixel_index] = 1'b1;
                    loaded_list.push_back(it.pixel_index);
                end
                return 1'b0;
            end
            MODE_RUN: begin
                last_peak = smooth_and_scale();
                res.result_kind  = KIND_RUN;
                res.result_value = last_peak;
                return 1'b1;
            end
            MODE_READ: begin
                res.result_kind  = KIND_READ;
                res.result_value = mask_img[it.pixel_index];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Presents one item, holding it until accepted, then records what is due.
    // A random idle gap before the item lowers valid for whole cycles.
    task automatic send_item(t_in_item it, bit check, t_out_item typed);
        t_out_item res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_item(it, res))
            pending_results.push_back(check ? typed : res);
    endtask

    // Waits until every result item has arrived, then lets the run or a
    // trailing load settle before anything touches the registers.
    task automatic drain();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic reg_sel, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'($urandom_range(32'hFF_FFFF, 0)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_WIDTH) reg_width = value;
        else reg_height = value;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(logic [1:0] m, int idx, int val);
        t_in_item it;
        it.mode        = m;
        it.pixel_index = idx[13:0];
        it.pixel_value = val[7:0];
        return it;
    endfunction

    function automatic void add_row(logic [1:0] m, int idx, int val, bit check,
                                    logic kind, logic [7:0] value);
        t_row row;
        row.item   = make_item(m, idx, val);
        row.check  = check;
        row.result = {kind, value};
        directed_rows.push_back(row);
    endfunction

    // Receiver: random stalls at the phase's rate, results checked in order.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: kind %0d value %0d",
                       o_out_data.result_kind, o_out_data.result_value);
                fail_count++;
            end else begin
                if (o_out_data.result_kind !== pending_results[0].result_kind) begin
                    $error("result_kind: expected %0d, got %0d",
                           pending_results[0].result_kind, o_out_data.result_kind);
                    fail_count++;
                end
                if (o_out_data.result_value !== pending_results[0].result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           pending_results[0].result_value, o_out_data.result_value);
                    fail_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    initial begin
        int sizes_w[6] = '{3, 16, 255, 2, 10, 5};
        int sizes_h[6] = '{3, 9, 3, 200, 12, 128};
        int ph, i, w, h, n, roll, runs, small_vals;
        t_out_item none;

        none           = '0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        reg_width      = 8'd128;
        reg_height     = 8'd128;
        last_peak      = '0;
        for (i = 0; i < DEPTH; i++) begin
            mask_img[i] = '0;
            loaded[i]   = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on a 3x3 mask reached by clamping zero and two up.
        write_reg(REG_WIDTH, 8'd0);
        write_reg(REG_HEIGHT, 8'd2);
        for (i = 0; i < 9; i++)
            add_row(MODE_LOAD, i, (i == 0) ? 255 : i * 29, 0, KIND_RUN, 0);
        add_row(MODE_READ, 0, 0, 1, KIND_READ, 8'd255);
        add_row(MODE_LOAD, DEPTH - 1, 170, 0, KIND_RUN, 0);
        add_row(MODE_READ, DEPTH - 1, 85, 1, KIND_READ, 8'd170);
        add_row(2'd3, DEPTH - 1, 255, 0, KIND_RUN, 0);
        add_row(MODE_READ, DEPTH - 1, 0, 1, KIND_READ, 8'd170);
        add_row(MODE_RUN, 0, 0, 0, KIND_RUN, 0);
        add_row(MODE_READ, 4, 0, 0, KIND_READ, 0);
        add_row(MODE_READ, 8, 0, 0, KIND_READ, 0);
        // An all-zero mask smooths to zero and leaves the peak at zero.
        for (i = 0; i < 9; i++)
            add_row(MODE_LOAD, i, 0, 0, KIND_RUN, 0);
        add_row(MODE_RUN, 0, 0, 1, KIND_RUN, 8'd0);
        add_row(MODE_READ, 0, 0, 1, KIND_READ, 8'd0);
        foreach (directed_rows[k])
            send_item(directed_rows[k].item, directed_rows[k].check, directed_rows[k].result);
        drain();

        // Random phases, one mask size each, idling profile rotating.
        for (ph = 0; ph < 6; ph++) begin
            write_reg(REG_WIDTH, sizes_w[ph][7:0]);
            write_reg(REG_HEIGHT, sizes_h[ph][7:0]);
            w = side_of(reg_width);
            h = side_of(reg_height);
            n = w * h;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            // Fill the whole window first so that every run reads loaded data.
            small_vals = $urandom_range(1);
            for (i = 0; i < n; i++)
                send_item(make_item(MODE_LOAD, i,
                          small_vals ? $urandom_range(7) : $urandom_range(255)), 0, none);
            runs = 0;
            for (i = 0; i < 50; i++) begin
                roll = $urandom_range(99);
                if (roll < 2 || (i == 49 && runs == 0)) begin
                    if (ph == 1 && runs == 0) drain();
                    send_item(make_item(MODE_RUN, $urandom_range(DEPTH - 1),
                              $urandom_range(255)), 0, none);
                    runs++;
                end else if (roll < 45) begin
                    send_item(make_item(MODE_LOAD, $urandom_range(n - 1),
                              $urandom_range(255)), 0, none);
                end else if (roll < 55) begin
                    send_item(make_item(MODE_LOAD, $urandom_range(DEPTH - 1),
                              $urandom_range(255)), 0, none);
                end else if (roll < 96) begin
                    send_item(make_item(MODE_READ,
                              loaded_list[$urandom_range(loaded_list.size() - 1)],
                              $urandom_range(255)), 0, none);
                end else begin
                    send_item(make_item(2'd3, $urandom_range(DEPTH - 1),
                              $urandom_range(255)), 0, none);
                end
            end
            drain();
        end

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("mask_smooth_and_normalize_unit_tb OK");
        end else begin
            $display("mask_smooth_and_normalize_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
